@@ design/e2r_pkg.sv @@
// e2r_pkg: widths, constants and payload types for the euler angle to rotation matrix block
// no dependencies; used by the channel interfaces and the top level
`default_nettype none
package e2r_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int FIELD_W        = 16;
  localparam int INT_FRAC       = 30;
  localparam int POLY_STEPS     = 8;
  localparam int LANES          = 6;

  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
  localparam logic [63:0] HALF_Q30    = 64'h2000_0000;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  // sine lanes
  localparam int L_SX = 0;
  localparam int L_CX = 1;
  localparam int L_SY = 2;
  localparam int L_CY = 3;
  localparam int L_SZ = 4;
  localparam int L_CZ = 5;

  typedef struct packed {
    logic [FIELD_W-1:0] angle_x;
    logic [FIELD_W-1:0] angle_y;
    logic [FIELD_W-1:0] angle_z;
  } angles_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] m00;
    logic signed [FIELD_W-1:0] m01;
    logic signed [FIELD_W-1:0] m02;
    logic signed [FIELD_W-1:0] m10;
    logic signed [FIELD_W-1:0] m11;
    logic signed [FIELD_W-1:0] m12;
    logic signed [FIELD_W-1:0] m20;
    logic signed [FIELD_W-1:0] m21;
    logic signed [FIELD_W-1:0] m22;
  } matrix_t;

endpackage
`default_nettype wire

@@ design/e2r_angles_if.sv @@
// e2r_angles_if: valid/ready channel carrying one angle triple
// depends on e2r_pkg
`default_nettype none
interface e2r_angles_if;
  logic              valid;
  logic              ready;
  e2r_pkg::angles_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/e2r_matrix_if.sv @@
// e2r_matrix_if: valid/ready channel carrying one rotation matrix
// depends on e2r_pkg
`default_nettype none
interface e2r_matrix_if;
  logic              valid;
  logic              ready;
  e2r_pkg::matrix_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/euler_to_rotation_matrix.sv @@
// euler_to_rotation_matrix: z-y-x euler angles to row-major rotation matrix Rz*Ry*Rx
// depends on e2r_pkg, e2r_angles_if, e2r_matrix_if
//
// Takes binary angles about x, y and z (one full turn = 2^ANGLE_BITS) and returns the nine
// matrix entries in signed Q1.14, saturated to +-16384. Fully pipelined: one transaction is
// accepted per cycle while the output is not stalled, and each result passes through all 32
// register stages of the pipeline. The six parallel sine lanes take 29 stages: quadrant fold,
// angle scaling, squaring, eight polynomial steps of three stages each (multiply, reciprocal
// divide, correct), the final multiply and the sign. Three product and rounding stages
// follow. Every stage has its own valid bit and loads whenever it is empty or its successor
// moves, so bubbles are squeezed out and a stalled output holds without losing anything.
`default_nettype none
module euler_to_rotation_matrix (
  input  wire logic   clk,
  input  wire logic   rst,
  e2r_angles_if.sink  angles,
  e2r_matrix_if.source matrix
);
  import e2r_pkg::*;

  localparam int ST_STEP0 = 3;
  localparam int ST_S     = ST_STEP0 + 3 * POLY_STEPS;
  localparam int ST_SV    = ST_S + 1;
  localparam int ST_P1    = ST_SV + 1;
  localparam int ST_P2    = ST_P1 + 1;
  localparam int ST_OUT   = ST_P2 + 1;
  localparam int NST      = ST_OUT + 1;
  localparam int OUT_SH   = INT_FRAC - COEF_FRAC_BITS;
  localparam logic [32:0] OUT_RND = (OUT_SH > 0) ? (33'd1 << (OUT_SH - 1)) : 33'd0;
  localparam logic [32:0] OUT_LIM = 33'd1 << COEF_FRAC_BITS;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  function automatic logic [31:0] umul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] pr;
    pr = {32'd0, a} * {32'd0, b} + HALF_Q30;
    return pr[61:30];
  endfunction

  function automatic logic signed [31:0] smul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] m;
    ma = a[31] ? 32'd0 - 32'(a) : 32'(a);
    mb = b[31] ? 32'd0 - 32'(b) : 32'(b);
    m  = umul(ma, mb);
    return signed'((a[31] ^ b[31]) ? 32'd0 - m : m);
  endfunction

  function automatic logic [FIELD_W-1:0] to_out(input logic signed [32:0] v);
    logic [32:0] m;
    logic [32:0] r;
    m = v[32] ? 33'd0 - 33'(v) : 33'(v);
    m = (m + OUT_RND) >> OUT_SH;
    if (m > OUT_LIM) begin
      m = OUT_LIM;
    end
    r = v[32] ? 33'd0 - m : m;
    return r[FIELD_W-1:0];
  endfunction

  function automatic logic signed [32:0] sx33(input logic signed [31:0] a);
    return signed'({a[31], a});
  endfunction

  logic [NST-1:0] vld;
  logic [NST:0]   en;

  // stage registers of the sine lanes
  logic [30:0]        t0  [LANES];
  logic [1:0]         qr  [0:ST_S][LANES];
  logic [30:0]        xr  [1:ST_S-1][LANES];
  logic [31:0]        x2r [2:ST_S-4][LANES];
  logic [31:0]        pr  [POLY_STEPS][LANES];
  logic [32:0]        nr  [POLY_STEPS][LANES];
  logic [31:0]        qer [POLY_STEPS][LANES];
  logic [30:0]        hr  [POLY_STEPS][LANES];
  logic [31:0]        sr  [LANES];
  logic signed [31:0] sv  [LANES];

  // product stages
  logic signed [31:0] czsy, szsy, c00, c10, c21, c22, szcx, szsx, czcx, czsx, nsy, sx1, cx1;
  logic signed [31:0] a01, a02, a11, a12;
  logic signed [31:0] d00, d10, d21, d22, dszcx, dszsx, dczcx, dczsx, dnsy;
  matrix_t            outr;

  logic [ANGLE_BITS-1:0] ang [LANES];

  assign en[NST] = matrix.ready;
  for (genvar i = 0; i < NST; i++) begin : g_en
    assign en[i] = !vld[i] || en[i+1];
  end

  assign angles.ready = en[0];
  assign matrix.valid = vld[NST-1];
  assign matrix.data  = outr;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= angles.valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // lane angles: sines at the angle, cosines a quarter turn later
  always_comb begin
    ang[L_SX] = ANGLE_BITS'(angles.data.angle_x);
    ang[L_SY] = ANGLE_BITS'(angles.data.angle_y);
    ang[L_SZ] = ANGLE_BITS'(angles.data.angle_z);
    ang[L_CX] = ANGLE_BITS'(angles.data.angle_x) + QUARTER;
    ang[L_CY] = ANGLE_BITS'(angles.data.angle_y) + QUARTER;
    ang[L_CZ] = ANGLE_BITS'(angles.data.angle_z) + QUARTER;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int l = 0; l < LANES; l++) begin
        qr[0][l] <= ang[l][ANGLE_BITS-1:ANGLE_BITS-2];
        // odd quadrants run the offset backwards
        t0[l] <= ang[l][ANGLE_BITS-2] ?
                 31'(ONE_Q30) - {1'b0, ang[l][ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}} :
                 {1'b0, ang[l][ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int l = 0; l < LANES; l++) begin
        xr[1][l] <= 31'(umul({1'b0, t0[l]}, HALF_PI_Q30));
      end
    end
    if (en[2]) begin
      for (int l = 0; l < LANES; l++) begin
        x2r[2][l] <= umul({1'b0, xr[1][l]}, {1'b0, xr[1][l]});
      end
    end
  end

  // carried operands
  for (genvar i = 1; i <= ST_S; i++) begin : g_q
    always_ff @(posedge clk) begin
      if (en[i]) begin
        qr[i] <= qr[i-1];
      end
    end
  end
  for (genvar i = 2; i <= ST_S - 1; i++) begin : g_x
    always_ff @(posedge clk) begin
      if (en[i]) begin
        xr[i] <= xr[i-1];
      end
    end
  end
  for (genvar i = 3; i <= ST_S - 4; i++) begin : g_x2
    always_ff @(posedge clk) begin
      if (en[i]) begin
        x2r[i] <= x2r[i-1];
      end
    end
  end

  // horner steps, highest term first
  for (genvar j = 0; j < POLY_STEPS; j++) begin : g_step
    localparam int K  = POLY_STEPS - j;
    localparam int SA = ST_STEP0 + 3 * j;
    localparam logic [31:0] DIV  = 32'((2 * K) * (2 * K + 1));
    localparam logic [31:0] RECP = 32'((64'd1 << 33) / DIV);

    always_ff @(posedge clk) begin
      if (en[SA]) begin
        for (int l = 0; l < LANES; l++) begin
          pr[j][l] <= umul(x2r[SA-1][l], (j == 0) ? ONE_Q30 : {1'b0, hr[(j == 0) ? 0 : j-1][l]});
        end
      end
    end

    always_ff @(posedge clk) begin
      logic [32:0] n;
      logic [65:0] m;
      if (en[SA+1]) begin
        for (int l = 0; l < LANES; l++) begin
          n = {1'b0, pr[j][l]} + 33'(DIV >> 1);
          m = {33'd0, n} * {34'd0, RECP};
          nr[j][l]  <= n;
          qer[j][l] <= m[64:33];
        end
      end
    end

    always_ff @(posedge clk) begin
      logic [40:0] qd;
      logic [32:0] r;
      logic [31:0] q;
      if (en[SA+2]) begin
        for (int l = 0; l < LANES; l++) begin
          // reciprocal estimate is low by at most one
          qd = {9'd0, qer[j][l]} * {9'd0, DIV};
          r  = nr[j][l] - qd[32:0];
          q  = qer[j][l] + 32'(r >= {1'b0, DIV});
          hr[j][l] <= (q > ONE_Q30) ? 31'd0 : 31'(ONE_Q30 - q);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] c;
    if (en[ST_S]) begin
      for (int l = 0; l < LANES; l++) begin
        sr[l] <= umul({1'b0, xr[ST_S-1][l]}, {1'b0, hr[POLY_STEPS-1][l]});
      end
    end
    if (en[ST_SV]) begin
      for (int l = 0; l < LANES; l++) begin
        c = (sr[l] > ONE_Q30) ? ONE_Q30 : sr[l];
        sv[l] <= signed'(qr[ST_S][l][1] ? 32'd0 - c : c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_P1]) begin
      czsy <= smul(sv[L_CZ], sv[L_SY]);
      szsy <= smul(sv[L_SZ], sv[L_SY]);
      c00  <= smul(sv[L_CZ], sv[L_CY]);
      c10  <= smul(sv[L_SZ], sv[L_CY]);
      c21  <= smul(sv[L_CY], sv[L_SX]);
      c22  <= smul(sv[L_CY], sv[L_CX]);
      szcx <= smul(sv[L_SZ], sv[L_CX]);
      szsx <= smul(sv[L_SZ], sv[L_SX]);
      czcx <= smul(sv[L_CZ], sv[L_CX]);
      czsx <= smul(sv[L_CZ], sv[L_SX]);
      nsy  <= -sv[L_SY];
      sx1  <= sv[L_SX];
      cx1  <= sv[L_CX];
    end
    if (en[ST_P2]) begin
      a01   <= smul(czsy, sx1);
      a02   <= smul(czsy, cx1);
      a11   <= smul(szsy, sx1);
      a12   <= smul(szsy, cx1);
      d00   <= c00;
      d10   <= c10;
      d21   <= c21;
      d22   <= c22;
      dszcx <= szcx;
      dszsx <= szsx;
      dczcx <= czcx;
      dczsx <= czsx;
      dnsy  <= nsy;
    end
    if (en[ST_OUT]) begin
      outr.m00 <= to_out(sx33(d00));
      outr.m01 <= to_out(sx33(a01) - sx33(dszcx));
      outr.m02 <= to_out(sx33(a02) + sx33(dszsx));
      outr.m10 <= to_out(sx33(d10));
      outr.m11 <= to_out(sx33(a11) + sx33(dczcx));
      outr.m12 <= to_out(sx33(a12) - sx33(dczsx));
      outr.m20 <= to_out(sx33(dnsy));
      outr.m21 <= to_out(sx33(d21));
      outr.m22 <= to_out(sx33(d22));
    end
  end

endmodule
`default_nettype wire

@@ sim/euler_to_rotation_matrix_tb.sv @@
// euler_to_rotation_matrix_tb: random and directed check of the euler angle to matrix block
// depends on e2r_pkg, e2r_angles_if, e2r_matrix_if and euler_to_rotation_matrix
`default_nettype none
module euler_to_rotation_matrix_tb;
  import e2r_pkg::*;

  localparam int LATENCY = 32;
  localparam int N_RANDOM = 400;

  logic clk;
  logic rst;
  bit failed;

  e2r_angles_if angles();
  e2r_matrix_if matrix();

  euler_to_rotation_matrix uut (
    .clk(clk),
    .rst(rst),
    .angles(angles.sink),
    .matrix(matrix.source)
  );

  // fixed point sine in q30, quarter-wave polynomial
  function automatic longint sine_q30(longint unsigned angle);
    longint unsigned a, quad, t, x, x2, h, s, d, p;
    a = angle & 64'hFFFF;
    quad = (a >> 14) & 3;
    t = (a & 64'h3FFF) << 16;
    if (quad[0]) t = 64'd1073741824 - t;
    x = (t * 64'd1686629713 + 64'd536870912) >> 30;
    x2 = (x * x + 64'd536870912) >> 30;
    h = 64'd1073741824;
    for (int k = POLY_STEPS; k >= 1; k--) begin
      d = longint'(2 * k) * longint'(2 * k + 1);
      p = (x2 * h + 64'd536870912) >> 30;
      p = (p + d / 2) / d;
      h = (p > 64'd1073741824) ? 0 : 64'd1073741824 - p;
    end
    s = (x * h + 64'd536870912) >> 30;
    if (s > 64'd1073741824) s = 64'd1073741824;
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    longint unsigned ma, mb, m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m = (ma * mb + 64'd536870912) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // round q30 to q1.14 half away from zero, saturate
  function automatic logic signed [15:0] to_coef(longint v);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + 64'd32768) >> 16;
    if (m > 16384) m = 16384;
    return (v < 0) ? -16'(m) : 16'(m);
  endfunction

  function automatic matrix_t rotation_of(angles_t a);
    matrix_t r;
    longint sx, cx, sy, cy, sz, cz, czsy, szsy;
    sx = sine_q30(a.angle_x); cx = sine_q30(a.angle_x + 16384);
    sy = sine_q30(a.angle_y); cy = sine_q30(a.angle_y + 16384);
    sz = sine_q30(a.angle_z); cz = sine_q30(a.angle_z + 16384);
    czsy = q30_mul(cz, sy);
    szsy = q30_mul(sz, sy);
    r.m00 = to_coef(q30_mul(cz, cy));
    r.m01 = to_coef(q30_mul(czsy, sx) - q30_mul(sz, cx));
    r.m02 = to_coef(q30_mul(czsy, cx) + q30_mul(sz, sx));
    r.m10 = to_coef(q30_mul(sz, cy));
    r.m11 = to_coef(q30_mul(szsy, sx) + q30_mul(cz, cx));
    r.m12 = to_coef(q30_mul(szsy, cx) - q30_mul(cz, sx));
    r.m20 = to_coef(-sy);
    r.m21 = to_coef(q30_mul(cy, sx));
    r.m22 = to_coef(q30_mul(cy, cx));
    return r;
  endfunction

  class matrix_scoreboard;
    matrix_t pending_q[$];

    function void note_angles(angles_t a);
      pending_q.push_back(rotation_of(a));
    endfunction

    function bit check_matrix(matrix_t got);
      matrix_t want;
      bit ok;
      ok = 1;
      if (pending_q.size() == 0) begin
        $error("matrix transaction with none expected: %h", got);
        return 0;
      end
      want = pending_q.pop_front();
      if (got.m00 !== want.m00) begin $error("m00 exp %0d got %0d", want.m00, got.m00); ok = 0; end
      if (got.m01 !== want.m01) begin $error("m01 exp %0d got %0d", want.m01, got.m01); ok = 0; end
      if (got.m02 !== want.m02) begin $error("m02 exp %0d got %0d", want.m02, got.m02); ok = 0; end
      if (got.m10 !== want.m10) begin $error("m10 exp %0d got %0d", want.m10, got.m10); ok = 0; end
      if (got.m11 !== want.m11) begin $error("m11 exp %0d got %0d", want.m11, got.m11); ok = 0; end
      if (got.m12 !== want.m12) begin $error("m12 exp %0d got %0d", want.m12, got.m12); ok = 0; end
      if (got.m20 !== want.m20) begin $error("m20 exp %0d got %0d", want.m20, got.m20); ok = 0; end
      if (got.m21 !== want.m21) begin $error("m21 exp %0d got %0d", want.m21, got.m21); ok = 0; end
      if (got.m22 !== want.m22) begin $error("m22 exp %0d got %0d", want.m22, got.m22); ok = 0; end
      return ok;
    endfunction
  endclass

  matrix_scoreboard board = new();
  angles_t directed_q[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // receiver stall pattern: runs of ready and stall, with some long open stretches
  initial begin
    int run;
    matrix.ready = 0;
    forever begin
      run = $urandom_range(1, 12);
      matrix.ready = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        matrix.ready = 1;
        run = 60;
      end
      repeat (run) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (angles.valid && angles.ready) board.note_angles(angles.data);
      if (matrix.valid && matrix.ready)
        if (!board.check_matrix(matrix.data)) failed = 1;
    end
  end

  // holds valid until the transaction is taken, at the falling edge
  task automatic send_angles(angles_t a);
    angles.valid <= 1;
    angles.data <= a;
    @(posedge clk);
    while (!angles.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_burst_gap();
    angles.valid <= 0;
    angles.data <= angles_t'(48'({$urandom, $urandom}));
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 3)) << 14;
      1: return (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    angles_t a;
    int burst;
    int waited;
    failed = 0;
    rst = 1;
    angles.valid = 0;
    angles.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // quadrant edges, full scale, and angles next to the quarter turns
    directed_q = '{'{16'h0000, 16'h0000, 16'h0000}, '{16'hFFFF, 16'hFFFF, 16'hFFFF},
                   '{16'h4000, 16'h0000, 16'h0000}, '{16'h0000, 16'h4000, 16'h0000},
                   '{16'h0000, 16'h0000, 16'h4000}, '{16'h8000, 16'h8000, 16'h8000},
                   '{16'hC000, 16'hC000, 16'hC000}, '{16'h3FFF, 16'h4001, 16'hBFFF},
                   '{16'h7FFF, 16'h8001, 16'hC001}, '{16'h0001, 16'h2000, 16'hE000},
                   '{16'h5555, 16'hAAAA, 16'h1234}, '{16'hAAAA, 16'h5555, 16'hEDCB},
                   '{16'h4000, 16'h4000, 16'h4000}, '{16'hC000, 16'h4000, 16'h8000},
                   '{16'h0000, 16'hC000, 16'h4000}, '{16'h2000, 16'h2000, 16'h2000}};
    foreach (directed_q[i]) send_angles(directed_q[i]);

    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
        a.angle_x = pick_angle();
        a.angle_y = pick_angle();
        a.angle_z = pick_angle();
        send_angles(a);
      end
      send_burst_gap();
    end
    angles.valid <= 0;

    waited = 0;
    while (board.pending_q.size() != 0 && waited < 100_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * LATENCY) @(posedge clk);
    if (failed || board.pending_q.size() != 0) begin
      if (board.pending_q.size() != 0)
        $error("%0d matrix transactions never arrived", board.pending_q.size());
      $display("Some tests failed");
    end else begin
      $display("All tests passed");
    end
    $finish;
  end
endmodule
`default_nettype wire
